>>> hw/rtl/hed_pkg.sv
// html entity decoder package: shared types, constants and lookup functions
// no dependencies
package hed_pkg;

  localparam logic [20:0] CpMax = 21'h10FFFF;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChAmp = 8'h26;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChLowX = 8'h78;
  localparam logic [7:0] ChUpX = 8'h58;
  localparam int NumNames = 48;

  // classified item handed from front to back
  typedef struct packed {
    logic       semi;      // ended on ';'
    logic       first;     // ended on its first byte
    logic       numeric;
    logic       dig_ok;    // digits seen, no digit error
    logic [20:0] cp;
    logic [3:0] len;       // position + 1 of the ending byte
    logic [NumNames-1:0] name_hit;
    logic       amp_first;
  } front_item_t;

  // name table, 7 bytes each, index 0 is the first character
  function automatic logic [55:0] name_str(input int idx);
    logic [55:0] s;
    s = '0;
    case (idx)
      0: s = {"amp", 32'h0};     1: s = {"lt", 40'h0};
      2: s = {"gt", 40'h0};      3: s = {"quot", 24'h0};
      4: s = {"apos", 24'h0};    5: s = {"rsquo", 16'h0};
      6: s = {"lsquo", 16'h0};   7: s = {"rdquo", 16'h0};
      8: s = {"ldquo", 16'h0};   9: s = {"nbsp", 24'h0};
      10: s = {"mdash", 16'h0};  11: s = {"ndash", 16'h0};
      12: s = {"hellip", 8'h0};  13: s = {"middot", 8'h0};
      14: s = {"bull", 24'h0};   15: s = {"copy", 24'h0};
      16: s = {"reg", 32'h0};    17: s = {"trade", 16'h0};
      18: s = {"times", 16'h0};  19: s = {"divide", 8'h0};
      20: s = {"deg", 32'h0};    21: s = {"laquo", 16'h0};
      22: s = {"raquo", 16'h0};  23: s = {"euro", 24'h0};
      24: s = {"rarr", 24'h0};   25: s = {"rArr", 24'h0};
      26: s = {"larr", 24'h0};   27: s = {"lArr", 24'h0};
      28: s = {"uarr", 24'h0};   29: s = {"darr", 24'h0};
      30: s = {"harr", 24'h0};   31: s = {"minus", 16'h0};
      32: s = {"plusmn", 8'h0};  33: s = {"prime", 16'h0};
      34: s = {"Prime", 16'h0};  35: s = {"sect", 24'h0};
      36: s = {"para", 24'h0};   37: s = {"dagger", 8'h0};
      38: s = {"Dagger", 8'h0};  39: s = {"cent", 24'h0};
      40: s = {"pound", 16'h0};  41: s = {"yen", 32'h0};
      42: s = {"micro", 16'h0};  43: s = {"frasl", 16'h0};
      44: s = {"lsaquo", 8'h0};  45: s = {"rsaquo", 8'h0};
      46: s = {"sbquo", 16'h0};  47: s = {"bdquo", 16'h0};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [6:0] name_char(input int idx);
    case (idx)
      0: return 7'h26;  1: return 7'h3C;  2: return 7'h3E;  3: return 7'h22;
      4, 5, 6, 33: return 7'h27;
      7, 8, 21, 22, 34, 47: return 7'h22;
      9: return 7'h20;
      10, 11, 30, 31: return 7'h2D;
      12: return 7'h2E;  13, 14: return 7'h2A;
      15, 39: return 7'h63;  16: return 7'h72;  17: return 7'h74;
      18: return 7'h78;  19, 43: return 7'h2F;  20: return 7'h6F;
      23: return 7'h45;  24, 25, 45: return 7'h3E;
      26, 27, 44: return 7'h3C;  28: return 7'h5E;  29: return 7'h76;
      32, 37, 38: return 7'h2B;  35: return 7'h53;  36: return 7'h50;
      40: return 7'h4C;  41: return 7'h59;  42: return 7'h75;
      46: return 7'h2C;
      default: return 7'h20;
    endcase
  endfunction

  function automatic int name_len(input int idx);
    logic [55:0] s;
    int n;
    s = name_str(idx);
    n = 0;
    for (int k = 0; k < 7; k++) begin
      if (s[55-8*k -: 8] != 8'h0) n = k + 1;
    end
    return n;
  endfunction

  function automatic logic [6:0] latin_fold(input logic [5:0] i);
    logic [511:0] t;
    t = {"AAAAAAACEEEEIIII", "DNOOOOOxOUUUUY s", "aaaaaaaceeeeiiii",
         "dnooooo/ouuuuy y"};
    return t[511-8*i - 1 -: 7];
  endfunction

  function automatic logic [6:0] fold_cp(input logic [20:0] v);
    logic [6:0] r;
    r = 7'h20;
    if (v >= 21'd32 && v < 21'd127) r = v[6:0];
    else begin
      case (v)
        21'h2018, 21'h2019, 21'h201A: r = 7'h27;
        21'h201C, 21'h201D, 21'h201E, 21'h00AB, 21'h00BB: r = 7'h22;
        21'h2013, 21'h2014: r = 7'h2D;
        21'h2026: r = 7'h2E;
        21'h2022, 21'h00B7: r = 7'h2A;
        21'h00A0: r = 7'h20;
        21'h00A9: r = 7'h63;
        21'h00AE: r = 7'h72;
        21'h2122: r = 7'h74;
        21'h00B0: r = 7'h6F;
        21'h20AC: r = 7'h45;
        default: begin
          if (v >= 21'hC0 && v <= 21'hFF) r = latin_fold(v[5:0]);
        end
      endcase
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/hed_front.sv
// front: scans bytes, tracks window state, digits and name matches per byte
// depends on hed_pkg
module hed_front import hed_pkg::*; #(
  parameter int MaxScan = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [7:0]  byte_value,
  input  logic        window_start,
  input  logic        buffer_end,
  input  logic        take,
  output logic        item_valid,
  output front_item_t item
);

  localparam int PosW = $clog2(MaxScan + 1);

  logic              window_active;
  logic [PosW-1:0]   byte_position;
  logic              numeric_mode, hex_mode, digit_seen, digit_error;
  logic [20:0]       code_point;
  logic [NumNames-1:0] alive;
  logic              amp_first;

  logic              act, num_n, hex_n, seen_n, err_n, amp_n, is_dig;
  logic [PosW-1:0]   p;
  logic [20:0]       cp_n;
  logic [24:0]       prod;
  logic [3:0]        dval;
  logic [NumNames-1:0] alive_n, hit;
  logic              ends, semi;
  logic [55:0]       nm;

  always_comb begin
    act = window_start | window_active;
    p = window_start ? '0 : byte_position;
    num_n = window_start ? 1'b0 : numeric_mode;
    hex_n = window_start ? 1'b0 : hex_mode;
    seen_n = window_start ? 1'b0 : digit_seen;
    err_n = window_start ? 1'b0 : digit_error;
    cp_n = window_start ? '0 : code_point;
    amp_n = window_start ? (byte_value == ChAmp) : amp_first;
    semi = byte_value == ChSemi;
    is_dig = 1'b0;
    dval = '0;
    if (byte_value >= "0" && byte_value <= "9") begin
      is_dig = 1'b1; dval = 4'(byte_value - "0");
    end else if (hex_n && byte_value >= "a" && byte_value <= "f") begin
      is_dig = 1'b1; dval = 4'(byte_value - "a" + 8'd10);
    end else if (hex_n && byte_value >= "A" && byte_value <= "F") begin
      is_dig = 1'b1; dval = 4'(byte_value - "A" + 8'd10);
    end
    prod = hex_n ? {cp_n, 4'h0} : ({4'h0, cp_n} << 3) + ({4'h0, cp_n} << 1);
    prod = prod + 25'(dval);
    if (!semi) begin
      if (p == PosW'(1) && byte_value == ChHash) num_n = 1'b1;
      else if (num_n && p == PosW'(2) && (byte_value == ChLowX || byte_value == ChUpX))
        hex_n = 1'b1;
      else if (num_n && p >= PosW'(2)) begin
        if (is_dig) begin
          cp_n = (prod > 25'(CpMax)) ? CpMax : prod[20:0];
          seen_n = 1'b1;
        end else err_n = 1'b1;
      end
    end
    // per-name match: name char k sits at window position k+1
    for (int t = 0; t < NumNames; t++) begin
      nm = name_str(t);
      alive_n[t] = window_start ? 1'b1 : alive[t];
      hit[t] = alive_n[t] && (int'(p) == name_len(t) + 1);
      if (p != '0) begin
        if (int'(p) > 7) alive_n[t] = 1'b0;
        else if (nm[55-8*(int'(p)-1) -: 8] != byte_value) alive_n[t] = 1'b0;
      end
    end
    ends = act && (semi || buffer_end || (int'(p) + 1 >= MaxScan));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_active <= 1'b0;
      item_valid <= 1'b0;
    end else begin
      item_valid <= (item_valid && !take) || (in_valid && ends);
      if (in_valid) begin
        if (act) begin
          window_active <= !ends;
          byte_position <= p + PosW'(1);
          numeric_mode <= num_n;
          hex_mode <= hex_n;
          digit_seen <= seen_n;
          digit_error <= err_n;
          code_point <= cp_n;
          alive <= alive_n;
          amp_first <= amp_n;
        end
        if (ends) begin
          item.semi <= semi;
          item.first <= p == '0;
          item.numeric <= num_n;
          item.dig_ok <= seen_n && !err_n;
          item.cp <= cp_n;
          item.len <= 4'(p + PosW'(1));
          item.name_hit <= hit;
          item.amp_first <= amp_n;
        end
      end
    end
  end

endmodule

>>> hw/rtl/hed_back.sv
// back: resolves a classified item into length and character
// depends on hed_pkg
module hed_back import hed_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  front_item_t item,
  output logic        take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  len_q,
  output logic [6:0]  char_q
);

  logic [3:0] len_c;
  logic [6:0] ch_c;

  assign take = item_valid && (!out_valid || !out_stall);

  always_comb begin
    len_c = '0;
    ch_c = '0;
    if (item.semi && !item.first) begin
      if (item.numeric) begin
        if (item.dig_ok) begin
          len_c = item.len; ch_c = fold_cp(item.cp);
        end
      end else if (item.amp_first) begin
        for (int t = NumNames - 1; t >= 0; t--) begin
          if (item.name_hit[t]) begin
            len_c = item.len; ch_c = name_char(t);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (take) begin
      out_valid <= 1'b1;
      len_q <= len_c;
      char_q <= ch_c;
    end else if (!out_stall) out_valid <= 1'b0;
  end

  assert property (@(posedge clk) disable iff (rst) len_q == 4'd0 && out_valid |-> char_q == 7'd0)
    else $error("char without length");
  assert property (@(posedge clk) disable iff (rst) out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");
  assert property (@(posedge clk) disable iff (rst) take |=> out_valid)
    else $error("taken item not shown");

endmodule

>>> hw/rtl/html_entity_decoder.sv
// html entity decoder top: front scanner, one-entry queue, back resolver
// depends on hed_pkg, hed_front, hed_back
// the item for the ending byte is registered in the front, the result in the back
// throughput: one byte per cycle, set by the per-byte name matcher, while in_stall is low
// reset: synchronous rst clears window and valid state
module html_entity_decoder import hed_pkg::*; #(
  parameter int MAX_SCAN = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_value,
  input  logic       window_start,
  input  logic       buffer_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] consumed_length,
  output logic [6:0] ascii_char
);

  logic        item_valid, take;
  front_item_t item;

  assign in_stall = item_valid && !take;

  hed_front #(.MaxScan(MAX_SCAN)) u_front (
    .clk, .rst, .in_valid(in_valid && !in_stall), .byte_value, .window_start,
    .buffer_end, .take, .item_valid, .item
  );

  hed_back u_back (
    .clk, .rst, .item_valid, .item, .take, .out_valid, .out_stall,
    .len_q(consumed_length), .char_q(ascii_char)
  );

endmodule
